// ----- sv/spq_pkg.sv -----
package spq_pkg;

  localparam int Depth  = 16;
  localparam int CountW = $clog2(Depth + 1);
  localparam int ValW   = 32;
  localparam int OccW   = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]             op;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [ValW-1:0] head_value;
    logic [1:0]             status;
    logic [OccW-1:0]        occupancy;
  } rsp_t;

  // action chosen by the controller at accept time
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_REMOVE,
    ACT_PEEK,
    ACT_OVERFLOW,
    ACT_UNDERFLOW
  } act_e;

  typedef struct packed {
    logic load;
    logic exec;
    act_e act;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

// ----- sv/spq_ctrl.sv -----
module spq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         op_i,
  input  spq_pkg::stat_t     stat_i,
  output spq_pkg::cmd_t      cmd_o,
  output logic               busy_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e         state_q;
  logic           busy_q;
  spq_pkg::act_e  act_q;
  spq_pkg::act_e  act_d;
  logic           load;

  assign load = start_i && !busy_q;

  // resolve error cases up front so the datapath just executes
  always_comb begin
    unique case (op_i)
      spq_pkg::OP_INSERT:
        act_d = stat_i.full ? spq_pkg::ACT_OVERFLOW : spq_pkg::ACT_INSERT;
      spq_pkg::OP_REMOVE:
        act_d = stat_i.empty ? spq_pkg::ACT_UNDERFLOW : spq_pkg::ACT_REMOVE;
      spq_pkg::OP_PEEK:
        act_d = stat_i.empty ? spq_pkg::ACT_UNDERFLOW : spq_pkg::ACT_PEEK;
      default:
        act_d = spq_pkg::ACT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      act_q   <= spq_pkg::ACT_NONE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (load) begin
            act_q   <= act_d;
            busy_q  <= 1'b1;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_o.load = load;
  assign cmd_o.exec = (state_q == S_EXEC);
  assign cmd_o.act  = act_q;
  assign busy_o     = busy_q;

endmodule

// ----- sv/spq_datapath.sv -----
module spq_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  spq_pkg::cmd_t                  cmd_i,
  input  logic signed [spq_pkg::ValW-1:0] value_i,
  output spq_pkg::stat_t                 stat_o,
  output spq_pkg::rsp_t                  rsp_o,
  output logic                           done_o
);

  logic signed [spq_pkg::ValW-1:0] entries_q [spq_pkg::Depth];
  logic signed [spq_pkg::ValW-1:0] entries_d [spq_pkg::Depth];
  logic signed [spq_pkg::ValW-1:0] ins_src   [spq_pkg::Depth];
  logic signed [spq_pkg::ValW-1:0] value_q;
  logic [spq_pkg::CountW-1:0]      count_q, count_d;
  logic [spq_pkg::Depth-1:0]       gt;
  spq_pkg::rsp_t                   rsp_q, rsp_d;
  logic                            done_q, done_d;

  // per-entry compare: valid entry strictly greater than the new value
  always_comb begin
    for (int i = 0; i < spq_pkg::Depth; i++) begin
      gt[i] = (spq_pkg::CountW'(i) < count_q) && (entries_q[i] > value_q);
    end
    ins_src[0] = value_q;
    for (int i = 1; i < spq_pkg::Depth; i++) begin
      ins_src[i] = gt[i-1] ? entries_q[i-1] : value_q;
    end
  end

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    if (cmd_i.exec) begin
      done_d           = 1'b1;
      rsp_d.head_value = '0;
      rsp_d.status     = spq_pkg::ST_OK;
      unique case (cmd_i.act)
        spq_pkg::ACT_INSERT: begin
          // slots from the insert point up to count take value or left neighbour
          for (int i = 0; i < spq_pkg::Depth; i++) begin
            if (gt[i] || (count_q == spq_pkg::CountW'(i))) begin
              entries_d[i] = ins_src[i];
            end
          end
          count_d = count_q + spq_pkg::CountW'(1);
        end
        spq_pkg::ACT_REMOVE: begin
          rsp_d.head_value = entries_q[0];
          for (int i = 0; i < spq_pkg::Depth - 1; i++) begin
            entries_d[i] = entries_q[i+1];
          end
          count_d = count_q - spq_pkg::CountW'(1);
        end
        spq_pkg::ACT_PEEK:      rsp_d.head_value = entries_q[0];
        spq_pkg::ACT_OVERFLOW:  rsp_d.status     = spq_pkg::ST_OVERFLOW;
        spq_pkg::ACT_UNDERFLOW: rsp_d.status     = spq_pkg::ST_UNDERFLOW;
        default: ;
      endcase
      rsp_d.occupancy = spq_pkg::OccW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
    rsp_q     <= rsp_d;
    if (cmd_i.load) begin
      value_q <= value_i;
    end
  end

  assign stat_o.full  = (count_q == spq_pkg::CountW'(spq_pkg::Depth));
  assign stat_o.empty = (count_q == '0);
  assign rsp_o        = rsp_q;
  assign done_o       = done_q;

endmodule

// ----- sv/sorted_insert_priority_queue.sv -----
// Ascending priority queue of up to spq_pkg::Depth signed 32-bit values,
// smallest at the head.
// Request channel: req_i carries op (insert, remove head, peek head) and the
// value to insert. A transfer happens on a rising edge with start high and
// busy low. busy rises on the following cycle and holds for one cycle while
// the entry array is updated in parallel (per-entry compare and shift).
// Response channel: done_o pulses for exactly one cycle with rsp_o holding
// head_value, status and occupancy; the receiver must take it then, there
// is no back-pressure.
// Sequence: the accepting edge moves the controller into its execute state,
// and done_o and rsp_o are registered from that state. A new start is taken
// only while busy is low, which holds in the same cycle as done_o, so the
// load/execute sequence takes no new request while one is executing.
// Errors: insert when full gives overflow, remove or peek when empty gives
// underflow; the store is left as it was. Op code 3 answers ok, no change.
// Reset clears the entry count and the controller; the entry storage
// itself is not reset, unused slots are never read.
module sorted_insert_priority_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  spq_pkg::req_t  req_i,
  output logic           busy,
  output logic           done_o,
  output spq_pkg::rsp_t  rsp_o
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  // controller: decodes op against full/empty and sequences the transfer
  spq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (req_i.op),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // datapath: sorted entry array, count and response register
  spq_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .value_i (req_i.value),
    .stat_o  (stat),
    .rsp_o   (rsp_o),
    .done_o  (done_o)
  );

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("response without an execute cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy ##1 done_o))
    else $error("accepted transfer did not execute and respond");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == spq_pkg::ST_OVERFLOW)
      |-> (rsp_o.occupancy == spq_pkg::OccW'(spq_pkg::Depth) && rsp_o.head_value == '0))
    else $error("overflow reported while not full");

  a_unf_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == spq_pkg::ST_UNDERFLOW)
      |-> (rsp_o.occupancy == '0 && rsp_o.head_value == '0))
    else $error("underflow reported while not empty");
`endif

endmodule
